>>> rtl/nvss_pkg.sv
// Package for the nearest-value sorted search core: sizes, command codes,
// the command record passed from front to back, and the search state type.
// No dependencies.
package nvss_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int DIFF_W      = VALUE_WIDTH + 1;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = 11;
   localparam int ENTRY_W     = 10;
   localparam int OUT_W       = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type             op;
      logic                   first;
      logic [IDX_W-1:0]       addr;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PROBE,
      ST_LO,
      ST_HI,
      ST_DEC
   } search_state_type;

endpackage

>>> rtl/nvss_front.sv
// Front end of the search core: takes items, classifies them and holds them
// in a short command queue for the back end. Depends on nvss_pkg.
module nvss_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_operation,
   input  logic [nvss_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [nvss_pkg::ENTRY_W-1:0] req_entry_index,
   input  logic                         req_first_key,
   output nvss_pkg::cmd_chan_type       cmd_chan,
   input  logic                         cmd_pop
);
   import nvss_pkg::*;

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           new_cmd;
   logic              accept;
   logic              keep;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (32'(p) == QUEUE_DEPTH - 1) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign req_full = (32'(count_ff) == QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   // Classify: drop loads aimed past the end of the table.
   always_comb begin
      new_cmd.op    = cmd_op_type'(req_operation);
      new_cmd.first = req_first_key;
      new_cmd.addr  = IDX_W'(req_entry_index);
      new_cmd.value = req_value;
      keep = (new_cmd.op == CMD_QUERY) || (32'(req_entry_index) < TABLE_DEPTH);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      if (cmd_pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
      if ((accept && keep) && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!(accept && keep) && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_chan.valid = (count_ff != '0);
   assign cmd_chan.cmd   = queue_ff[rd_ptr_ff];

endmodule

>>> rtl/nvss_back.sv
// Back end of the search core: table memory, binary search sequencer and the
// result register. Depends on nvss_pkg.
module nvss_back (
   input  logic                       clock,
   input  logic                       reset,
   input  nvss_pkg::cmd_chan_type     cmd_chan,
   output logic                       cmd_pop,
   input  logic [nvss_pkg::LEN_W-1:0] table_length,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [nvss_pkg::OUT_W-1:0] rsp_match_index
);
   import nvss_pkg::*;

   logic [VALUE_WIDTH-1:0]   mem [TABLE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic                     mem_we;
   logic                     mem_rd;
   logic [IDX_W-1:0]         rd_addr;

   search_state_type         state_ff, state_in;
   logic [IDX_W-1:0]         start_ff, start_in;
   logic [IDX_W-1:0]         end_ff, end_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic [IDX_W-1:0]         lower_bound_ff, lower_bound_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] lo_ff, lo_in;
   logic signed [DIFF_W-1:0] dlo_ff, dlo_in;
   logic signed [DIFF_W-1:0] dhi_ff, dhi_in;
   logic                     out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]         out_index_ff, out_index_in;

   logic [IDX_W:0]           len_eff;
   logic [IDX_W-1:0]         last_idx;
   logic [IDX_W-1:0]         first_start;
   logic [IDX_W-1:0]         new_start;
   logic [IDX_W-1:0]         new_end;
   logic [IDX_W-1:0]         result;

   function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[IDX_W:1];
   endfunction

   function automatic logic span_open(input logic [IDX_W-1:0] a,
                                      input logic [IDX_W-1:0] b);
      return ({1'b0, a} + 1'b1) < {1'b0, b};
   endfunction

   // Clamp the length into 1..TABLE_DEPTH and the start into the valid range.
   always_comb begin
      if (table_length == '0) begin
         len_eff = (IDX_W+1)'(1);
      end else if (32'(table_length) > TABLE_DEPTH) begin
         len_eff = (IDX_W+1)'(TABLE_DEPTH);
      end else begin
         len_eff = (IDX_W+1)'(table_length);
      end
      last_idx    = IDX_W'(len_eff - 1'b1);
      first_start = cmd_chan.cmd.first ? '0 : lower_bound_ff;
      if (first_start > last_idx) begin
         first_start = last_idx;
      end
   end

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      mid_in         = mid_ff;
      lower_bound_in = lower_bound_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      dlo_in         = dlo_ff;
      dhi_in         = dhi_ff;
      out_index_in   = out_index_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      cmd_pop        = 1'b0;
      mem_we         = 1'b0;
      mem_rd         = 1'b0;
      rd_addr        = '0;
      new_start      = start_ff;
      new_end        = end_ff;
      result         = start_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               cmd_pop = 1'b1;
               if (cmd_chan.cmd.op == CMD_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  key_in   = $signed(cmd_chan.cmd.value);
                  start_in = first_start;
                  end_in   = last_idx;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            mem_rd = 1'b1;
            if (span_open(start_ff, end_ff)) begin
               rd_addr  = mid_of(start_ff, end_ff);
               mid_in   = rd_addr;
               state_in = ST_PROBE;
            end else begin
               rd_addr  = start_ff;
               state_in = ST_LO;
            end
         end
         ST_PROBE: begin
            // Narrow the interval and issue the next probe in the same cycle.
            if (key_ff == rd_data_ff) begin
               new_start = mid_ff;
               new_end   = mid_ff;
            end else if (key_ff < rd_data_ff) begin
               new_end = mid_ff;
            end else begin
               new_start = mid_ff;
            end
            start_in = new_start;
            end_in   = new_end;
            mem_rd   = 1'b1;
            if (span_open(new_start, new_end)) begin
               rd_addr = mid_of(new_start, new_end);
               mid_in  = rd_addr;
            end else begin
               rd_addr  = new_start;
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            lo_in    = rd_data_ff;
            mem_rd   = 1'b1;
            rd_addr  = end_ff;
            state_in = ST_HI;
         end
         ST_HI: begin
            dlo_in   = $signed({key_ff[VALUE_WIDTH-1], key_ff})
                     - $signed({lo_ff[VALUE_WIDTH-1], lo_ff});
            dhi_in   = $signed({rd_data_ff[VALUE_WIDTH-1], rd_data_ff})
                     - $signed({key_ff[VALUE_WIDTH-1], key_ff});
            state_in = ST_DEC;
         end
         ST_DEC: begin
            result = (dlo_ff > dhi_ff) ? end_ff : start_ff;
            if (!out_valid_ff || rsp_pop) begin
               lower_bound_in = result;
               out_index_in   = OUT_W'(32'(result) + 1);
               out_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lower_bound_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lower_bound_ff <= lower_bound_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      end_ff       <= end_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      dlo_ff       <= dlo_in;
      dhi_ff       <= dhi_in;
      out_index_ff <= out_index_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_chan.cmd.addr] <= cmd_chan.cmd.value;
      end
      if (mem_rd) begin
         rd_data_ff <= $signed(mem[rd_addr]);
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_match_index = out_index_ff;

endmodule

>>> rtl/nearest_value_sorted_search_core.sv
// Top level of the nearest-value sorted search core: length register, front
// command queue and back search engine. Depends on nvss_pkg, nvss_front, nvss_back.
//
//   channel  ports                                  handshake
//   req      operation, value, entry_index, first   push / full
//   rsp      match_index                            pop / empty
//   csr      write_data (table_length)              write_enable
//
// A load is written to the table memory in the same cycle it leaves the queue.
// A query in the back end reads the table through its single read port: one
// probe per cycle, then one read each for the two neighbours, over a span set
// by the clamped table length and narrowed by the carried lower bound.
// Reset is synchronous; it clears control state and sets table_length to 1,
// but leaves the table memory as it is, so read only entries already loaded.
// full rises when the two-entry queue is full; a result waits in its
// register, and the back end holds only if a further result is ready first.
module nearest_value_sorted_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_operation,
   input  logic [nvss_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [nvss_pkg::ENTRY_W-1:0]     req_entry_index,
   input  logic                             req_first_key,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [nvss_pkg::OUT_W-1:0]       rsp_match_index,
   input  logic                             csr_write_enable,
   input  logic [nvss_pkg::LEN_W-1:0]       csr_write_data
);
   import nvss_pkg::*;

   logic [LEN_W-1:0] table_length_ff, table_length_in;
   cmd_chan_type     cmd_chan;
   logic             cmd_pop;

   // Hold the length until software writes a new one.
   assign table_length_in = csr_write_enable ? csr_write_data : table_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= LEN_W'(1);
      end else begin
         table_length_ff <= table_length_in;
      end
   end

   nvss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_entry_index (req_entry_index),
      .req_first_key   (req_first_key),
      .cmd_chan        (cmd_chan),
      .cmd_pop         (cmd_pop)
   );

   nvss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_chan        (cmd_chan),
      .cmd_pop         (cmd_pop),
      .table_length    (table_length_ff),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_match_index (rsp_match_index)
   );

`ifndef ASSERT_OFF
   // The back end never takes a command from an empty queue.
   a_pop_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_chan.valid)
      else $error("command popped from empty queue");

   // A result shown is always a one-based index inside the table.
   a_index_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_match_index != '0) &&
                     (32'(rsp_match_index) <= TABLE_DEPTH))
      else $error("match index out of range");

   // Reset leaves no result waiting.
   a_reset_empty : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty)
      else $error("result present after reset");
`endif

endmodule
